FILE: hw/rtl/fccw_pkg.sv
// Package for the FAT cluster chain walker: shared types, codes and constants.
// It depends on nothing else. The step logic, the top level and the checker use it.
package fccw_pkg;

  // Input operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_FAT   = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FAT   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Table format codes. Code three behaves like FAT32.
  localparam logic [1:0] TYPE_FAT12 = 2'd0;
  localparam logic [1:0] TYPE_FAT16 = 2'd1;
  localparam logic [1:0] TYPE_FAT32 = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FAT_TYPE         = 3'd0;
  localparam logic [2:0] CFG_RESERVED_SECTORS = 3'd1;
  localparam logic [2:0] CFG_FAT_COPIES       = 3'd2;
  localparam logic [2:0] CFG_SECTORS_PER_FAT  = 3'd3;
  localparam logic [2:0] CFG_ROOT_DIR_ENTRIES = 3'd4;
  localparam logic [2:0] CFG_SECTOR_LOG2      = 3'd5;
  localparam logic [2:0] CFG_CLUSTER_LOG2     = 3'd6;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // Sector size limits, as log2 of bytes.
  localparam logic [3:0] SECTOR_LOG2_MIN = 4'd9;
  localparam logic [3:0] SECTOR_LOG2_MAX = 4'd12;

  // Every directory entry takes 32 bytes; data clusters are numbered from 2.
  localparam int DirEntryLog2 = 5;
  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

  // Configuration registers.
  typedef struct packed {
    logic [1:0]  fat_type;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] sectors_per_fat;
    logic [15:0] root_dir_entries;
    logic [3:0]  sector_size_log2;
    logic [2:0]  cluster_sectors_log2;
  } cfg_t;

  // One input transaction.
  typedef struct packed {
    logic        op;
    logic [27:0] first_cluster;
    logic [31:0] file_size;
    logic [31:0] fat_word;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sector;
    logic [19:0] byte_count;
    logic [31:0] fat_byte_offset;
    logic        last;
  } result_t;

  // Walk state kept between items.
  typedef struct packed {
    logic [27:0] current_cluster;
    logic [31:0] bytes_left;
    logic        walking;
  } walk_state_t;

endpackage

FILE: hw/rtl/fccw_step.sv
// Step logic of the FAT cluster chain walker: one item in, up to two results out.
// Purely combinational; depends on fccw_pkg for the types and codes.
module fccw_step (
  input  fccw_pkg::cfg_t        cfg,
  input  fccw_pkg::item_t       item,
  input  fccw_pkg::walk_state_t state,
  output fccw_pkg::walk_state_t state_next,
  output logic [1:0]            num_results,
  output fccw_pkg::result_t     result0,
  output fccw_pkg::result_t     result1
);
  import fccw_pkg::*;

  logic [3:0]  sl;
  logic [27:0] next_cluster;
  logic [27:0] c;
  logic [31:0] c32;
  logic [31:0] bytes;
  logic        proceed;
  logic        end_of_chain;
  logic [23:0] fat_area;
  logic [21:0] root_bytes;
  logic [21:0] bps_m1;
  logic [21:0] root_secs;
  logic [31:0] sector;
  logic [4:0]  clus_log2;
  logic [19:0] clus_bytes;
  logic [19:0] count;
  logic [31:0] base;
  logic [31:0] offset;

  // Sector size is clamped to the supported range.
  always_comb begin
    if (cfg.sector_size_log2 < SECTOR_LOG2_MIN) begin
      sl = SECTOR_LOG2_MIN;
    end else if (cfg.sector_size_log2 > SECTOR_LOG2_MAX) begin
      sl = SECTOR_LOG2_MAX;
    end else begin
      sl = cfg.sector_size_log2;
    end
  end

  // Pull the next cluster number out of the delivered table word.
  always_comb begin
    case (cfg.fat_type)
      TYPE_FAT12: begin
        if (state.current_cluster[0]) begin
          next_cluster = 28'(item.fat_word[15:4]);
        end else begin
          next_cluster = 28'(item.fat_word[11:0]);
        end
      end
      TYPE_FAT16: next_cluster = 28'(item.fat_word[15:0]);
      default:    next_cluster = item.fat_word[27:0];
    endcase
  end

  // Cluster and byte budget this item works on.
  assign proceed = (item.op == OP_START) || state.walking;
  assign c       = (item.op == OP_START) ? item.first_cluster : next_cluster;
  assign bytes   = (item.op == OP_START) ? item.file_size : state.bytes_left;
  assign c32     = 32'(c);

  // End-of-chain marks fill the top of each format's cluster range.
  always_comb begin
    case (cfg.fat_type)
      TYPE_FAT12: end_of_chain = &c[11:3];
      TYPE_FAT16: end_of_chain = &c[15:3];
      default:    end_of_chain = &c[27:3];
    endcase
  end

  // First sector of the cluster: tables, root directory, then the data area.
  assign fat_area   = 24'(cfg.fat_copies) * 24'(cfg.sectors_per_fat);
  assign bps_m1     = (22'd1 << sl) - 22'd1;
  assign root_bytes = 22'({cfg.root_dir_entries, DirEntryLog2'(0)}) + bps_m1;
  assign root_secs  = root_bytes >> sl;
  assign sector     = 32'(cfg.reserved_sectors) + 32'(fat_area) + 32'(root_secs)
                    + ((c32 - FIRST_DATA_CLUSTER) << cfg.cluster_sectors_log2);

  // Bytes taken from this cluster.
  assign clus_log2  = 5'(sl) + 5'(cfg.cluster_sectors_log2);
  assign clus_bytes = 20'd1 << clus_log2;
  assign count      = (bytes < 32'(clus_bytes)) ? bytes[19:0] : clus_bytes;

  // Byte offset of this cluster's table entry.
  assign base = 32'(cfg.reserved_sectors) << sl;
  always_comb begin
    case (cfg.fat_type)
      TYPE_FAT12: offset = base + c32 + (c32 >> 1);
      TYPE_FAT16: offset = base + (c32 << 1);
      default:    offset = base + (c32 << 2);
    endcase
  end

  // Results and the state left behind.
  always_comb begin
    state_next  = state;
    num_results = 2'd0;
    result0     = '0;
    result1     = '0;
    if (proceed) begin
      state_next.current_cluster = c;
      state_next.bytes_left      = bytes;
      if (end_of_chain) begin
        state_next.walking = 1'b0;
        num_results        = 2'd1;
        result0.kind       = KIND_DONE;
        result0.last       = 1'b1;
      end else if (bytes == 32'd0) begin
        state_next.walking = 1'b0;
        num_results        = 2'd1;
        result0.kind       = KIND_ERROR;
        result0.last       = 1'b1;
      end else begin
        state_next.walking    = 1'b1;
        state_next.bytes_left = bytes - 32'(count);
        num_results           = 2'd2;
        result0.kind          = KIND_DATA;
        result0.sector        = sector;
        result0.byte_count    = count;
        result1.kind            = KIND_FAT;
        result1.fat_byte_offset = offset;
        result1.last            = 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/fat_cluster_chain_walker.sv
// Top level of the FAT cluster chain walker: configuration, input register, result buffer.
// Depends on fccw_pkg and fccw_step.
//
//   channel  | direction | handshake                  | payload
//   item     | in        | item_valid / item_stall    | op, first_cluster, file_size, fat_word
//   result   | out       | result_valid / result_stall| kind, sector, byte_count,
//            |           |                            | fat_byte_offset, last
//   cfg      | in        | cfg_wen (no wait)          | cfg_index, cfg_data
//
// An accepted item waits in the input register until the result buffer can take its
// results; they then move into the result buffer, from which the first is offered.
// The single result port drains one result per cycle while result_stall is low; an
// item that gives a data read and a table read holds the buffer until both are taken,
// and the next item moves in as the last of them is taken.
// Synchronous reset clears the walk state and buffers and loads register defaults.
// A stalled result holds the buffer; the input register then holds and stalls the item side.
module fat_cluster_chain_walker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 op,
  input  logic [27:0]                          first_cluster,
  input  logic [31:0]                          file_size,
  input  logic [31:0]                          fat_word,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [1:0]                           kind,
  output logic [31:0]                          sector,
  output logic [19:0]                          byte_count,
  output logic [31:0]                          fat_byte_offset,
  output logic                                 last,
  input  logic                                 cfg_wen,
  input  logic [fccw_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [fccw_pkg::CfgDataWidth-1:0]    cfg_data
);
  import fccw_pkg::*;

  cfg_t        cfg;
  item_t       item_q;
  logic        item_q_valid;
  walk_state_t state;
  walk_state_t state_next;
  logic [1:0]  num_results;
  result_t     step_r0;
  result_t     step_r1;
  result_t     slot0;
  result_t     slot1;
  logic [1:0]  cnt;
  logic        take;
  logic        move;
  logic        accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat_type             <= TYPE_FAT16;
      cfg.reserved_sectors     <= 16'd1;
      cfg.fat_copies           <= 8'd2;
      cfg.sectors_per_fat      <= 16'd9;
      cfg.root_dir_entries     <= 16'd224;
      cfg.sector_size_log2     <= 4'd9;
      cfg.cluster_sectors_log2 <= 3'd0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_FAT_TYPE:         cfg.fat_type             <= cfg_data[1:0];
        CFG_RESERVED_SECTORS: cfg.reserved_sectors     <= cfg_data;
        CFG_FAT_COPIES:       cfg.fat_copies           <= cfg_data[7:0];
        CFG_SECTORS_PER_FAT:  cfg.sectors_per_fat      <= cfg_data;
        CFG_ROOT_DIR_ENTRIES: cfg.root_dir_entries     <= cfg_data;
        CFG_SECTOR_LOG2:      cfg.sector_size_log2     <= cfg_data[3:0];
        CFG_CLUSTER_LOG2:     cfg.cluster_sectors_log2 <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Handshake control: the input register moves on when the buffer can take its results.
  assign take         = result_valid && !result_stall;
  assign move         = item_q_valid && ((cnt == 2'd0) || ((cnt == 2'd1) && take));
  assign item_stall   = item_q_valid && !move;
  assign accept       = item_valid && !item_stall;
  assign result_valid = (cnt != 2'd0);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (accept) begin
      item_q_valid <= 1'b1;
    end else if (move) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.op            <= op;
      item_q.first_cluster <= first_cluster;
      item_q.file_size     <= file_size;
      item_q.fat_word      <= fat_word;
    end
  end

  // Chain step for the registered item.
  fccw_step u_step (
    .cfg         (cfg),
    .item        (item_q),
    .state       (state),
    .state_next  (state_next),
    .num_results (num_results),
    .result0     (step_r0),
    .result1     (step_r1)
  );

  // Walk state advances once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (move) begin
      state <= state_next;
    end
  end

  // Two-entry result buffer; slot0 is the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (move) begin
      cnt <= num_results;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      slot0 <= step_r0;
      slot1 <= step_r1;
    end else if (take) begin
      slot0 <= slot1;
    end
  end

  assign kind            = slot0.kind;
  assign sector          = slot0.sector;
  assign byte_count      = slot0.byte_count;
  assign fat_byte_offset = slot0.fat_byte_offset;
  assign last            = slot0.last;

endmodule

FILE: hw/rtl/fccw_checker.sv
// Port-level checker for the FAT cluster chain walker, bound to the top level.
// Depends on fccw_pkg for the result kind codes.
module fccw_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  kind,
  input logic        last
);
  import fccw_pkg::*;

  // A stalled result stays offered with the same kind.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(kind)))
    else $error("result changed while stalled");

  // A data read is never the final result of an item.
  a_data_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_DATA) |-> !last)
    else $error("data read marked last");

  // Table reads, done and error always close an item.
  a_other_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (kind == KIND_FAT || kind == KIND_DONE || kind == KIND_ERROR))
      |-> last)
    else $error("closing result not marked last");

  // A taken data read is followed at once by its table read.
  a_data_then_fat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && kind == KIND_DATA)
      |=> (result_valid && kind == KIND_FAT))
    else $error("data read not followed by table read");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered after reset");

endmodule

bind fat_cluster_chain_walker fccw_checker u_fccw_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .kind         (kind),
  .last         (last)
);
